>>> sv/bff_pkg.sv
// shared types and constants for the best-fit free list
package bff_pkg;

  typedef logic [1:0] status_t;

  localparam status_t STAT_DONE  = 2'd0;
  localparam status_t STAT_NOFIT = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_TAKE   = 1'b1;

  localparam int SIZE_W  = 16;
  localparam int OFF_W   = 32;
  localparam int COUNT_W = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCHK,
    ST_TRD,
    ST_TGOT,
    ST_SHIFT,
    ST_PUT,
    ST_OUT
  } state_t;

endpackage

>>> sv/bff_if.sv
// request and result channel interfaces
interface bff_req_if import bff_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SIZE_W-1:0] slot_size;
  logic [OFF_W-1:0]  slot_offset;

  modport source (output valid, req_type, slot_size, slot_offset, input ready);
  modport sink   (input valid, req_type, slot_size, slot_offset, output ready);
endinterface

interface bff_res_if import bff_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [OFF_W-1:0]   found_offset;
  logic               next_valid;
  logic [OFF_W-1:0]   next_offset;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, status, found_offset, next_valid, next_offset,
                  entry_count, input ready);
  modport sink   (input valid, status, found_offset, next_valid, next_offset,
                  entry_count, output ready);
endinterface

>>> sv/bff_ram.sv
// generic simple dual-port ram with registered read
module bff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/best_fit_free_list.sv
// best-fit free list: sorted (size, offset) table held in one ram
// a search of about log2(fill+1) steps halves the range; an insert then moves larger
//   entries up and writes the new one, a take reads the found entry and moves later
//   ones down; no fit ends after the search, a full table skips it; a stalled result
//   adds its wait; one request at a time, the next taken once the result is registered
// reset: rst_n synchronous, clears the fill count and control; ram is not cleared
module best_fit_free_list import bff_pkg::*; #(
  parameter int ENTRIES = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  bff_req_if.sink  in_chan,
  bff_res_if.source out_chan
);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int DW = SIZE_W + OFF_W;

  state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, cnt_r, cnt_nxt;
  logic          typ_r, typ_nxt;
  logic [SIZE_W-1:0] sz_r, sz_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [AW-1:0] pend_a_r, pend_a_nxt;
  status_t       rst_r, rst_nxt;
  logic [OFF_W-1:0] fnd_r, fnd_nxt, nxo_r, nxo_nxt;
  logic          nxv_r, nxv_nxt;
  logic          ov_r, ov_nxt;
  status_t       o_st_r, o_st_nxt;
  logic [OFF_W-1:0] o_fnd_r, o_fnd_nxt, o_nxo_r, o_nxo_nxt;
  logic          o_nxv_r, o_nxv_nxt;
  logic [COUNT_W-1:0] o_cnt_r, o_cnt_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [CW:0]   sum;
  logic [CW-1:0] mid;
  logic          pred;
  logic          in_acc;

  bff_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid    = sum[CW:1];
  assign in_acc = in_chan.valid && in_chan.ready;
  // insert seeks the first larger size, take the first size not smaller
  assign pred   = (typ_r == REQ_INSERT) ? (rdata[DW-1:OFF_W] <= sz_r)
                                        : (rdata[DW-1:OFF_W] <  sz_r);

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = ov_r;
  assign out_chan.status       = o_st_r;
  assign out_chan.found_offset = o_fnd_r;
  assign out_chan.next_valid   = o_nxv_r;
  assign out_chan.next_offset  = o_nxo_r;
  assign out_chan.entry_count  = o_cnt_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.req_type == REQ_INSERT && fill_r >= CW'(ENTRIES)) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_SRD;
          end
        end
      end
      ST_SRD: begin
        if (lo_r < hi_r) begin
          state_nxt = ST_SCHK;
        end else if (typ_r == REQ_INSERT) begin
          state_nxt = (fill_r > lo_r) ? ST_SHIFT : ST_PUT;
        end else begin
          state_nxt = (lo_r >= fill_r) ? ST_OUT : ST_TRD;
        end
      end
      ST_SCHK: state_nxt = ST_SRD;
      ST_TRD:  state_nxt = ST_TGOT;
      ST_TGOT: state_nxt = ST_SHIFT;
      ST_SHIFT: begin
        if (typ_r == REQ_INSERT) begin
          if (cnt_r <= lo_r) state_nxt = ST_PUT;
        end else begin
          if ({1'b0, cnt_r} + 1'b1 >= {1'b0, fill_r}) state_nxt = ST_PUT;
        end
      end
      ST_PUT: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!ov_r || out_chan.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    fill_nxt   = fill_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    cnt_nxt    = cnt_r;
    typ_nxt    = typ_r;
    sz_nxt     = sz_r;
    off_nxt    = off_r;
    pend_v_nxt = 1'b0;
    pend_a_nxt = pend_a_r;
    rst_nxt    = rst_r;
    fnd_nxt    = fnd_r;
    nxv_nxt    = nxv_r;
    nxo_nxt    = nxo_r;
    ov_nxt     = ov_r;
    o_st_nxt   = o_st_r;
    o_fnd_nxt  = o_fnd_r;
    o_nxv_nxt  = o_nxv_r;
    o_nxo_nxt  = o_nxo_r;
    o_cnt_nxt  = o_cnt_r;
    raddr      = mid[AW-1:0];
    we         = 1'b0;
    waddr      = pend_a_r;
    wdata      = rdata;

    if (ov_r && out_chan.ready) ov_nxt = 1'b0;

    // a moved entry is written back in the cycle after its read
    if (pend_v_r) begin
      we = 1'b1;
      if (typ_r == REQ_TAKE && pend_a_r == lo_r[AW-1:0]) begin
        nxv_nxt = 1'b1;
        nxo_nxt = rdata[OFF_W-1:0];
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          typ_nxt = in_chan.req_type;
          sz_nxt  = in_chan.slot_size;
          off_nxt = in_chan.slot_offset;
          lo_nxt  = '0;
          hi_nxt  = fill_r;
          rst_nxt = (in_chan.req_type == REQ_INSERT && fill_r >= CW'(ENTRIES))
                    ? STAT_FULL : STAT_DONE;
          fnd_nxt = '0;
          nxv_nxt = 1'b0;
          nxo_nxt = '0;
        end
      end
      ST_SRD: begin
        raddr = mid[AW-1:0];
        if (!(lo_r < hi_r)) begin
          cnt_nxt = (typ_r == REQ_INSERT) ? fill_r : lo_r;
          if (typ_r == REQ_TAKE && lo_r >= fill_r) rst_nxt = STAT_NOFIT;
        end
      end
      ST_SCHK: begin
        if (pred) lo_nxt = mid + 1'b1;
        else      hi_nxt = mid;
      end
      ST_TRD: raddr = lo_r[AW-1:0];
      ST_TGOT: fnd_nxt = rdata[OFF_W-1:0];
      ST_SHIFT: begin
        if (typ_r == REQ_INSERT) begin
          if (cnt_r > lo_r) begin
            raddr      = AW'(cnt_r - 1'b1);
            pend_v_nxt = 1'b1;
            pend_a_nxt = cnt_r[AW-1:0];
            cnt_nxt    = cnt_r - 1'b1;
          end
        end else begin
          if ({1'b0, cnt_r} + 1'b1 < {1'b0, fill_r}) begin
            raddr      = AW'(cnt_r + 1'b1);
            pend_v_nxt = 1'b1;
            pend_a_nxt = cnt_r[AW-1:0];
            cnt_nxt    = cnt_r + 1'b1;
          end
        end
      end
      ST_PUT: begin
        if (typ_r == REQ_INSERT) begin
          we       = 1'b1;
          waddr    = lo_r[AW-1:0];
          wdata    = {sz_r, off_r};
          fill_nxt = fill_r + 1'b1;
        end else begin
          fill_nxt = fill_r - 1'b1;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_chan.ready) begin
          ov_nxt    = 1'b1;
          o_st_nxt  = rst_r;
          o_fnd_nxt = fnd_r;
          o_nxv_nxt = nxv_r;
          o_nxo_nxt = nxo_r;
          o_cnt_nxt = COUNT_W'(fill_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    cnt_r    <= cnt_nxt;
    typ_r    <= typ_nxt;
    sz_r     <= sz_nxt;
    off_r    <= off_nxt;
    pend_a_r <= pend_a_nxt;
    rst_r    <= rst_nxt;
    fnd_r    <= fnd_nxt;
    nxv_r    <= nxv_nxt;
    nxo_r    <= nxo_nxt;
    o_st_r   <= o_st_nxt;
    o_fnd_r  <= o_fnd_nxt;
    o_nxv_r  <= o_nxv_nxt;
    o_nxo_r  <= o_nxo_nxt;
    o_cnt_r  <= o_cnt_nxt;
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(ENTRIES))
    else $error("fill count beyond table depth");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUT |-> !pend_v_r)
    else $error("pending move collides with final write");

  a_fill_only_in_put: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_PUT |=> fill_r == $past(fill_r))
    else $error("fill count changed outside update");
`endif
endmodule
